### hw/rtl/hdlcfx_pkg.sv
// hdlcfx_pkg: types and constants shared by the hdlc fax frame receiver
// no dependencies; imported by hdlcfx_crc, hdlcfx_ctrl, hdlc_fax_frame_receiver and the bench
`default_nettype none

package hdlcfx_pkg;

	// symbol codes
	localparam logic [2:0] OP_DATA    = 3'd0;
	localparam logic [2:0] OP_FLAG    = 3'd1;
	localparam logic [2:0] OP_ABORT   = 3'd2;
	localparam logic [2:0] OP_TIMEOUT = 3'd3;
	localparam logic [2:0] OP_START   = 3'd4;

	// result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LONG  = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_CRC_ERR   = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd4;
	localparam logic [2:0] ST_BAD_CTRL  = 3'd5;
	localparam logic [2:0] ST_TIMEOUT   = 3'd6;

	// receiver phases
	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_COUNT  = 2'd1;
	localparam logic [1:0] PH_GATHER = 2'd2;

	// frame checks
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_PRESET  = 16'hffff;
	localparam logic [15:0] CRC_RESIDUE = 16'h1d0f;
	localparam logic [7:0]  ADDR_ALL    = 8'hff;
	localparam logic [7:0]  CTRL_CMD    = 8'hc0;
	localparam logic [7:0]  CTRL_FINAL  = 8'hc8;
	localparam int          MIN_FRAME_BYTES = 5;
	localparam int          FRAME_OVERHEAD  = 4;
	localparam logic [3:0]  MIN_FLAGS_RESET = 4'd10;
	localparam logic [3:0]  FLAG_COUNT_MAX  = 4'd15;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic [2:0] status;
		logic [7:0] frame_length;
		logic       final_frame;
	} out_t;

endpackage

`default_nettype wire

### hw/rtl/hdlc_fax_frame_receiver.sv
// hdlc_fax_frame_receiver: top level, input register, receiver core, result register
// depends on hdlcfx_pkg, hdlcfx_ctrl (and through it hdlcfx_crc)
//
// channel   direction  handshake             payload
// in        receive    in_valid / in_ready   in_data (op, data_byte)
// out       send       out_valid / out_ready out_data (kind .. final_frame)
// cfg       receive    cfg_we                cfg_wdata (min_preamble_flags)
//
// one symbol per cycle sustained unless the result register stalls; a symbol is held in the
// input register; its result (if any) enters the result register as the symbol is consumed
// all the per-symbol work, byte-wide crc included, is one combinational pass
// a stalled result register holds the input register, and in_ready drops only
// when both are full
// arst_n clears valids, receiver state and the preamble setting (10 flags)
`default_nettype none

module hdlc_fax_frame_receiver #(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hdlcfx_pkg::in_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hdlcfx_pkg::out_t      out_data,
	input  wire logic             cfg_we,
	input  wire logic [3:0]       cfg_wdata
);
	import hdlcfx_pkg::*;

	logic       valid_s1;
	in_t        item_s1;
	logic       advance;
	logic       res_valid;
	out_t       res;
	logic       out_valid_q;
	out_t       out_data_q;
	logic [3:0] min_flags_q;

	// preamble setting; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_flags_q <= MIN_FLAGS_RESET;
		end else if (cfg_we) begin
			min_flags_q <= cfg_wdata;
		end
	end

	// symbol leaves the input register whenever the result slot is free or draining
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	hdlcfx_ctrl #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (valid_s1 && advance),
		.item       (item_s1),
		.min_flags  (min_flags_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register, loaded as the symbol is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### hw/rtl/hdlcfx_crc.sv
// hdlcfx_crc: byte-wide crc-16-ccitt update, msb first
// depends on hdlcfx_pkg
`default_nettype none

module hdlcfx_crc (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);
	import hdlcfx_pkg::*;

	always_comb begin
		logic [15:0] r;
		logic        fb;
		r = crc_in;
		for (int j = 0; j < 8; j++) begin
			fb = r[15] ^ data[7 - j];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		crc_out = r;
	end

endmodule

`default_nettype wire

### hw/rtl/hdlcfx_ctrl.sv
// hdlcfx_ctrl: receiver state, flag hunting, byte gathering and frame verdict
// depends on hdlcfx_pkg and hdlcfx_crc
`default_nettype none

module hdlcfx_ctrl #(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_valid,
	input  wire hdlcfx_pkg::in_t    item,
	input  wire logic [3:0]         min_flags,
	output logic                    res_valid,
	output hdlcfx_pkg::out_t        res
);
	import hdlcfx_pkg::*;

	localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

	logic [1:0]       phase_q, phase_d;
	logic [3:0]       flag_count_q, flag_count_d;
	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       ctl_q, ctl_d;
	logic             preamble_q, preamble_d;

	// frame state as seen by the current symbol (cleared when gathering starts)
	logic [CNT_W-1:0] eff_count;
	logic [15:0]      eff_crc;
	logic [7:0]       eff_addr;
	logic [7:0]       eff_ctl;
	logic             gather;
	logic             from_count;
	logic [15:0]      crc_next;

	always_comb begin
		from_count = (phase_q == PH_COUNT) && (item.op != OP_FLAG)
			&& !(preamble_q && (flag_count_q < min_flags));
		eff_count = from_count ? '0 : byte_count_q;
		eff_crc   = from_count ? CRC_PRESET : crc_q;
		eff_addr  = from_count ? 8'h00 : addr_q;
		eff_ctl   = from_count ? 8'h00 : ctl_q;
	end

	hdlcfx_crc u_crc (
		.crc_in  (eff_crc),
		.data    (item.data_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		phase_d      = phase_q;
		flag_count_d = flag_count_q;
		byte_count_d = byte_count_q;
		crc_d        = crc_q;
		addr_d       = addr_q;
		ctl_d        = ctl_q;
		preamble_d   = preamble_q;
		res_valid    = 1'b0;
		res          = '0;
		gather       = 1'b0;
		if (step_valid) begin
			case (item.op)
				OP_START: begin
					phase_d      = PH_HUNT;
					flag_count_d = '0;
					preamble_d   = 1'b1;
					byte_count_d = '0;
					crc_d        = CRC_PRESET;
					addr_d       = '0;
					ctl_d        = '0;
				end
				OP_TIMEOUT: begin
					phase_d      = PH_HUNT;
					flag_count_d = '0;
					byte_count_d = '0;
					crc_d        = CRC_PRESET;
					addr_d       = '0;
					ctl_d        = '0;
					res_valid    = 1'b1;
					res.kind     = KIND_VERDICT;
					res.status   = ST_TIMEOUT;
				end
				OP_DATA, OP_FLAG, OP_ABORT: begin
					if (phase_q == PH_COUNT) begin
						if (item.op == OP_FLAG) begin
							if (flag_count_q != FLAG_COUNT_MAX) begin
								flag_count_d = flag_count_q + 4'd1;
							end
						end else if (!from_count) begin
							// preamble too short, drop the symbol
							phase_d      = PH_HUNT;
							flag_count_d = '0;
						end else begin
							gather = 1'b1;
						end
					end else if (phase_q == PH_GATHER) begin
						gather = 1'b1;
					end else if (item.op == OP_FLAG) begin
						phase_d      = PH_COUNT;
						flag_count_d = 4'd1;
					end else begin
						phase_d = PH_HUNT;
					end

					if (gather) begin
						phase_d      = PH_GATHER;
						byte_count_d = eff_count;
						crc_d        = eff_crc;
						addr_d       = eff_addr;
						ctl_d        = eff_ctl;
						if (item.op == OP_FLAG) begin
							// closing flag doubles as first flag of the next preamble
							res_valid = 1'b1;
							res.kind  = KIND_VERDICT;
							if (eff_count < CNT_W'(MIN_FRAME_BYTES)) begin
								res.status = ST_TOO_SHORT;
							end else if (eff_crc != CRC_RESIDUE) begin
								res.status = ST_CRC_ERR;
							end else if (eff_addr != ADDR_ALL) begin
								res.status = ST_BAD_ADDR;
							end else if (eff_ctl != CTRL_CMD && eff_ctl != CTRL_FINAL) begin
								res.status = ST_BAD_CTRL;
							end else begin
								res.status       = ST_OK;
								res.frame_length = 8'(eff_count - CNT_W'(FRAME_OVERHEAD));
								res.final_frame  = eff_ctl[3];
								preamble_d       = eff_ctl[3];
							end
							phase_d      = PH_COUNT;
							flag_count_d = 4'd1;
							byte_count_d = '0;
							crc_d        = CRC_PRESET;
							addr_d       = '0;
							ctl_d        = '0;
						end else if (eff_count >= CNT_W'(MAX_MESSAGE_BYTES)) begin
							res_valid    = 1'b1;
							res.kind     = KIND_VERDICT;
							res.status   = ST_TOO_LONG;
							phase_d      = PH_HUNT;
							flag_count_d = '0;
							byte_count_d = '0;
							crc_d        = CRC_PRESET;
							addr_d       = '0;
							ctl_d        = '0;
						end else if (item.op == OP_DATA) begin
							if (eff_count == CNT_W'(0)) begin
								addr_d = item.data_byte;
							end else if (eff_count == CNT_W'(1)) begin
								ctl_d = item.data_byte;
							end
							crc_d          = crc_next;
							byte_count_d   = eff_count + CNT_W'(1);
							res_valid      = 1'b1;
							res.kind       = KIND_BYTE;
							res.byte_value = item.data_byte;
							res.byte_index = 8'(eff_count);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			flag_count_q <= '0;
			byte_count_q <= '0;
			crc_q        <= CRC_PRESET;
			addr_q       <= '0;
			ctl_q        <= '0;
			preamble_q   <= 1'b1;
		end else begin
			phase_q      <= phase_d;
			flag_count_q <= flag_count_d;
			byte_count_q <= byte_count_d;
			crc_q        <= crc_d;
			addr_q       <= addr_d;
			ctl_q        <= ctl_d;
			preamble_q   <= preamble_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(MAX_MESSAGE_BYTES))
		else $error("byte count past message limit");

	a_counting_has_flag: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COUNT |-> flag_count_q != 4'd0)
		else $error("counting phase with no flag seen");

	a_empty_crc_preset: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q == CNT_W'(0) |-> crc_q == CRC_PRESET)
		else $error("crc not preset on empty frame");

	a_result_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step_valid)
		else $error("result without a symbol");

endmodule

`default_nettype wire

### verif/tb_hdlc_fax_frame_receiver.sv
// tb_hdlc_fax_frame_receiver: self-checking bench for the hdlc fax frame receiver
// depends on hdlcfx_pkg and hdlc_fax_frame_receiver; predicts echoes and verdicts per symbol
// directed symbols first, then random messages under four idle mixes and a long output hold
`default_nettype none

module tb_hdlc_fax_frame_receiver;
	import hdlcfx_pkg::*;

	localparam int MSG_BYTES    = 256;
	localparam int SETTLE_CYCLES = 8;       // two register stages plus margin
	localparam int HOLD_CYCLES   = 120;     // long output hold-off
	localparam int RANDOM_ITEMS  = 30;      // per idle mix
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// ways a random frame gets spoiled
	typedef enum int {
		FAULT_NONE,
		FAULT_SHORT,
		FAULT_FCS,
		FAULT_ADDR,
		FAULT_CTRL,
		FAULT_ABORTS,
		FAULT_TIMEOUT
	} frame_fault_e;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we    = 1'b0;
	logic [3:0] cfg_wdata = MIN_FLAGS_RESET;

	// receiver state as the bench believes it to be
	logic [1:0]  rx_phase     = PH_HUNT;
	logic [3:0]  flag_cnt     = '0;
	logic [8:0]  byte_cnt     = '0;
	logic [15:0] fcs_acc      = CRC_PRESET;
	logic [7:0]  addr_byte    = '0;
	logic [7:0]  ctrl_byte    = '0;
	logic        preamble_req = 1'b1;
	logic [3:0]  min_flags    = MIN_FLAGS_RESET;

	in_t  symbols_to_send [$];   // symbols not yet offered
	out_t rx_results_due [$];    // echoes and verdicts still to come
	int   symbols_queued = 0;
	int   items_taken    = 0;
	int   errors         = 0;
	int   send_idle_pct  = 0;
	int   stall_pct      = 0;
	logic hold_rx        = 1'b0;

	hdlc_fax_frame_receiver #(
		.MAX_MESSAGE_BYTES(MSG_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// msb-first ccitt update, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		int i;
		for (i = 7; i >= 0; i--) begin
			acc = {acc[14:0], 1'b0} ^ ((acc[15] ^ b[i]) ? CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	task automatic clear_frame();
		byte_cnt  = '0;
		fcs_acc   = CRC_PRESET;
		addr_byte = '0;
		ctrl_byte = '0;
	endtask

	// advance the receiver by one accepted symbol, queue what it must emit
	task automatic receive_symbol(input in_t sym);
		out_t r;
		r = '0;
		r.kind = KIND_VERDICT;
		case (sym.op)
			OP_START: begin
				rx_phase = PH_HUNT;
				flag_cnt = '0;
				preamble_req = 1'b1;
				clear_frame();
			end
			OP_TIMEOUT: begin
				// any phase; preamble requirement survives
				rx_phase = PH_HUNT;
				flag_cnt = '0;
				clear_frame();
				r.status = ST_TIMEOUT;
				rx_results_due.push_back(r);
			end
			OP_DATA, OP_FLAG, OP_ABORT: begin
				if (rx_phase == PH_COUNT) begin
					if (sym.op == OP_FLAG) begin
						if (flag_cnt != FLAG_COUNT_MAX) flag_cnt = flag_cnt + 4'd1;
						return;
					end
					// preamble too short: drop the symbol and hunt again
					if (preamble_req && flag_cnt < min_flags) begin
						rx_phase = PH_HUNT;
						flag_cnt = '0;
						return;
					end
					rx_phase = PH_GATHER;
					clear_frame();
				end
				if (rx_phase == PH_GATHER) begin
					if (sym.op == OP_FLAG) begin
						// closing flag: verdict, and it opens the next preamble
						if (int'(byte_cnt) < MIN_FRAME_BYTES) begin
							r.status = ST_TOO_SHORT;
						end else if (fcs_acc != CRC_RESIDUE) begin
							r.status = ST_CRC_ERR;
						end else if (addr_byte != ADDR_ALL) begin
							r.status = ST_BAD_ADDR;
						end else if (ctrl_byte != CTRL_CMD && ctrl_byte != CTRL_FINAL) begin
							r.status = ST_BAD_CTRL;
						end else begin
							r.status = ST_OK;
							r.frame_length = 8'(int'(byte_cnt) - FRAME_OVERHEAD);
							r.final_frame = ctrl_byte[3];
							preamble_req = ctrl_byte[3];
						end
						rx_results_due.push_back(r);
						clear_frame();
						rx_phase = PH_COUNT;
						flag_cnt = 4'd1;
					end else if (int'(byte_cnt) >= MSG_BYTES) begin
						// message full, data and abort alike
						r.status = ST_TOO_LONG;
						rx_results_due.push_back(r);
						clear_frame();
						rx_phase = PH_HUNT;
						flag_cnt = '0;
					end else if (sym.op == OP_DATA) begin
						if (byte_cnt == 9'd0) addr_byte = sym.data_byte;
						else if (byte_cnt == 9'd1) ctrl_byte = sym.data_byte;
						fcs_acc = crc_step(fcs_acc, sym.data_byte);
						r.kind = KIND_BYTE;
						r.byte_value = sym.data_byte;
						r.byte_index = byte_cnt[7:0];
						rx_results_due.push_back(r);
						byte_cnt = byte_cnt + 9'd1;
					end
				end else if (sym.op == OP_FLAG) begin
					rx_phase = PH_COUNT;
					flag_cnt = 4'd1;
				end else begin
					rx_phase = PH_HUNT;
				end
			end
			default: ;    // unused codes leave everything alone
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("%0t mismatch %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	task automatic push_symbol(input logic [2:0] op, input logic [7:0] b);
		in_t s;
		s.op = op;
		s.data_byte = b;
		symbols_to_send.push_back(s);
		symbols_queued++;
	endtask

	// address, control, payload and complemented fcs (high byte first), optionally one bit flipped and aborts mixed in
	task automatic push_frame(input logic [7:0] addr, input logic [7:0] ctrl,
			input int payload_len, input bit spoil_fcs, input int abort_pct);
		logic [7:0]  body [$];
		logic [15:0] acc;
		int k;
		body.push_back(addr);
		body.push_back(ctrl);
		for (k = 0; k < payload_len; k++) body.push_back(8'($urandom));
		acc = CRC_PRESET;
		for (k = 0; k < body.size(); k++) acc = crc_step(acc, body[k]);
		acc = ~acc;
		body.push_back(acc[15:8]);
		body.push_back(acc[7:0]);
		if (spoil_fcs) begin
			k = int'($urandom_range(body.size() - 1));
			body[k] = body[k] ^ (8'h01 << $urandom_range(7));
		end
		for (k = 0; k < body.size(); k++) begin
			if (int'($urandom_range(99)) < abort_pct) push_symbol(OP_ABORT, 8'($urandom));
			push_symbol(OP_DATA, body[k]);
		end
	endtask

	// one message: optional restart, preamble, a few frames, a little noise
	task automatic push_message();
		int n_flags;
		int n_frames;
		int f;
		int len;
		int pick;
		frame_fault_e fault;
		logic [7:0] ctrl;
		if ($urandom_range(3) == 0) push_symbol(OP_START, 8'($urandom));
		n_flags = int'(min_flags) + int'($urandom_range(1, 3));
		if ($urandom_range(5) == 0) n_flags = int'($urandom_range(int'(min_flags)));
		repeat (n_flags) push_symbol(OP_FLAG, 8'($urandom));
		n_frames = int'($urandom_range(1, 4));
		for (f = 0; f < n_frames; f++) begin
			len = int'($urandom_range(1, 12));
			// only the last frame of a message is marked final
			ctrl = (f == n_frames - 1) ? CTRL_FINAL : CTRL_CMD;
			pick = int'($urandom_range(11));
			fault = (pick > int'(FAULT_TIMEOUT)) ? FAULT_NONE : frame_fault_e'(pick);
			case (fault)
				FAULT_SHORT: repeat ($urandom_range(3)) push_symbol(OP_DATA, 8'($urandom));
				FAULT_FCS: push_frame(ADDR_ALL, ctrl, len, 1'b1, 0);
				FAULT_ADDR: push_frame(8'($urandom), ctrl, len, 1'b0, 0);
				FAULT_CTRL: push_frame(ADDR_ALL, 8'($urandom), len, 1'b0, 0);
				FAULT_ABORTS: push_frame(ADDR_ALL, ctrl, len, 1'b0, 25);
				FAULT_TIMEOUT: begin
					// link drops mid-frame, message is over
					repeat ($urandom_range(6)) push_symbol(OP_DATA, 8'($urandom));
					push_symbol(OP_TIMEOUT, 8'($urandom));
					return;
				end
				default: push_frame(ADDR_ALL, ctrl, len, 1'b0, 0);
			endcase
			repeat ($urandom_range(1, 2)) push_symbol(OP_FLAG, 8'($urandom));
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) push_symbol(3'($urandom_range(7)), 8'($urandom));
		end
	endtask

	// wait until every offered symbol is taken and every result is back
	task automatic drain();
		do @(negedge clk);
		while (symbols_to_send.size() != 0 || in_valid || rx_results_due.size() != 0);
		// symbols without a result may still sit inside the block
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_min_flags(input logic [3:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		min_flags = v;
	endtask

	// ---------------------------------------------------------------
	// input driver: one transaction per accepted symbol
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				receive_symbol(in_data);
				items_taken <= items_taken + 1;
			end
			// slot is free unless the current symbol is still waiting
			if (!in_valid || in_ready) begin
				if (symbols_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= symbols_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// output monitor: compare each result transaction with the oldest due
	// ---------------------------------------------------------------
	always @(posedge clk) begin : rx_check
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rx_results_due.size() == 0) begin
					report_mismatch("result with nothing due", int'(out_data), 0);
				end else begin
					want = rx_results_due.pop_front();
					if (out_data.kind !== want.kind)
						report_mismatch("kind", int'(out_data.kind), int'(want.kind));
					if (out_data.byte_value !== want.byte_value)
						report_mismatch("byte_value", int'(out_data.byte_value),
							int'(want.byte_value));
					if (out_data.byte_index !== want.byte_index)
						report_mismatch("byte_index", int'(out_data.byte_index),
							int'(want.byte_index));
					if (out_data.status !== want.status)
						report_mismatch("status", int'(out_data.status), int'(want.status));
					if (out_data.frame_length !== want.frame_length)
						report_mismatch("frame_length", int'(out_data.frame_length),
							int'(want.frame_length));
					if (out_data.final_frame !== want.final_frame)
						report_mismatch("final_frame", int'(out_data.final_frame),
							int'(want.final_frame));
				end
			end
			out_ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
		end
	end

	// long output hold-off while the sender keeps offering: block fills, in_ready drops
	initial begin : rx_hold_off
		int n;
		wait (arst_n);
		while (items_taken < 40) @(negedge clk);
		@(posedge clk);
		hold_rx <= 1'b1;
		for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// run limit
	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// sequencing: reset, directed symbols, then four idle mixes
	// ---------------------------------------------------------------
	initial begin : stimulus
		int ph;
		int mark;
		logic [3:0] setting;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one opening flag is enough for the directed part
		write_min_flags(4'd1);
		@(negedge clk);
		// hunting ignores data, aborts and unused codes
		push_symbol(OP_DATA, 8'h00);
		push_symbol(OP_ABORT, 8'hff);
		push_symbol(OP_UNUSED_HI, 8'hff);
		// abort right after the flag ends counting and is skipped
		push_symbol(OP_FLAG, 8'h00);
		push_symbol(OP_ABORT, 8'h00);
		// shortest good frame, final: length 1, re-arms the preamble
		push_frame(ADDR_ALL, CTRL_FINAL, 1, 1'b0, 0);
		push_symbol(OP_FLAG, 8'hff);
		// valid fcs but only four bytes: too short
		push_frame(ADDR_ALL, CTRL_CMD, 0, 1'b0, 0);
		push_symbol(OP_FLAG, 8'h00);
		// partial frame cut by a timeout, then unused code and restart
		push_symbol(OP_DATA, 8'hff);
		push_symbol(OP_TIMEOUT, 8'h00);
		push_symbol(OP_UNUSED_LO, 8'h00);
		push_symbol(OP_START, 8'hff);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					setting = 4'd0;
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					setting = FLAG_COUNT_MAX;
					send_idle_pct = 70;
					stall_pct = 0;
				end
				2: begin
					setting = MIN_FLAGS_RESET;
					send_idle_pct = 0;
					stall_pct = 70;
				end
				default: begin
					setting = 4'($urandom_range(15));
					send_idle_pct = 9;
					stall_pct = 9;
				end
			endcase
			write_min_flags(setting);
			@(negedge clk);
			// one full 256-byte message, overrun by a further data byte
			if (ph == 0) begin
				push_symbol(OP_START, 8'($urandom));
				repeat (int'(min_flags) + 1) push_symbol(OP_FLAG, 8'($urandom));
				push_frame(ADDR_ALL, CTRL_CMD, MSG_BYTES - FRAME_OVERHEAD, 1'b0, 0);
				push_symbol(OP_DATA, 8'($urandom));
			end
			mark = symbols_queued;
			while (symbols_queued < mark + RANDOM_ITEMS) push_message();
			drain();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/hdlcfx_pkg.sv
hw/rtl/hdlcfx_crc.sv
hw/rtl/hdlcfx_ctrl.sv
hw/rtl/hdlc_fax_frame_receiver.sv
verif/tb_hdlc_fax_frame_receiver.sv
